// File: src/aubs_pkg.sv
`timescale 1ns / 1ps

package aubs_pkg;

  // Width of the internal byte positions; they saturate at PosMax.
  localparam int unsigned PosBits  = 32;
  localparam logic [PosBits-1:0] PosMax = '1;

  localparam int unsigned OutBits  = 32;

  localparam logic [4:0] TypeMask      = 5'h1f;
  localparam logic [4:0] SliceTypeMin  = 5'd1;
  localparam logic [4:0] SliceTypeMax  = 5'd5;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One access unit as reported on the output stream.
  typedef struct packed {
    logic               last;
    logic [OutBits-1:0] length;
    logic [OutBits-1:0] start;
  } unit_t;

  // Results produced by one input byte, compacted: unit[0] is the first.
  typedef struct packed {
    logic [1:0] count;
    unit_t      unit1;
    unit_t      unit0;
  } push_t;

endpackage

// File: src/aubs_scan.sv
`timescale 1ns / 1ps

module aubs_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_stream_i,
  output aubs_pkg::push_t push_o
);

  localparam int unsigned PW = aubs_pkg::PosBits;

  logic [PW-1:0] pos_q, pos_d;
  logic [23:0]   recent_q, recent_d;
  logic [PW-1:0] chunk_q, chunk_d;
  logic [PW-1:0] search_q, search_d;
  logic [PW-1:0] group_q, group_d;
  logic          open_q, open_d;
  logic          seen_q, seen_d;
  logic          long_q, long_d;
  logic [4:0]    type_q, type_d;
  logic          known_q, known_d;

  logic [PW-1:0] pos_i;
  logic          hit;
  logic          slice_cur;
  logic          slice_end;
  logic          emit_a;
  logic          emit_b;
  logic [PW-1:0] len_a;
  logic [PW-1:0] len_b;
  logic [PW:0]   search_sum;
  logic [PW-1:0] off;
  logic          off_ok;
  aubs_pkg::unit_t unit_a;
  aubs_pkg::unit_t unit_b;

  always_comb begin
    pos_i  = pos_q - PW'(3);
    hit    = (pos_q >= PW'(3))
           && ((recent_q == 24'h000001) || ((recent_q == 24'h0) && (data_byte_i == 8'h01)))
           && (pos_i >= search_q);
    slice_cur = known_q && (type_q >= aubs_pkg::SliceTypeMin)
              && (type_q <= aubs_pkg::SliceTypeMax);
    emit_a = hit && seen_q && slice_cur;
    len_a  = (pos_i >= group_q) ? (pos_i - group_q) : '0;
    search_sum = {1'b0, pos_i} + (PW+1)'(4);

    chunk_d  = chunk_q;
    search_d = search_q;
    group_d  = group_q;
    open_d   = open_q;
    seen_d   = seen_q;
    long_d   = long_q;
    type_d   = type_q;
    known_d  = known_q;

    // Start code accepted: the previous NAL closes here.
    if (hit) begin
      chunk_d = pos_i;
      if (emit_a || !open_q) begin
        group_d = pos_i;
      end
      open_d   = 1'b1;
      seen_d   = 1'b1;
      search_d = (search_sum > {1'b0, aubs_pkg::PosMax}) ? aubs_pkg::PosMax
                                                         : search_sum[PW-1:0];
      long_d   = (recent_q[7:0] == 8'h00);
      type_d   = '0;
      known_d  = 1'b0;
    end

    // Header byte sits three or four bytes into the chunk.
    off_ok = (pos_q >= chunk_d);
    off    = pos_q - chunk_d;
    if (off_ok && (off == PW'(2)) && !known_d) begin
      long_d = (data_byte_i == 8'h00);
    end else if (off_ok && !known_d
                 && (((off == PW'(3)) && !long_d) || ((off == PW'(4)) && long_d))) begin
      type_d  = data_byte_i[4:0] & aubs_pkg::TypeMask;
      known_d = 1'b1;
    end

    recent_d = {recent_q[15:0], data_byte_i};
    pos_d    = (pos_q == aubs_pkg::PosMax) ? pos_q : (pos_q + PW'(1));

    slice_end = known_d && (type_d >= aubs_pkg::SliceTypeMin)
              && (type_d <= aubs_pkg::SliceTypeMax);
    emit_b = end_of_stream_i && slice_end;
    len_b  = (pos_d >= group_d) ? (pos_d - group_d) : '0;

    unit_a.start  = aubs_pkg::OutBits'(group_q);
    unit_a.length = aubs_pkg::OutBits'(len_a);
    unit_a.last   = !emit_b;
    unit_b.start  = aubs_pkg::OutBits'(group_d);
    unit_b.length = aubs_pkg::OutBits'(len_b);
    unit_b.last   = 1'b1;

    push_o.count = accept_i ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
    push_o.unit0 = emit_a ? unit_a : unit_b;
    push_o.unit1 = unit_b;

    // End of stream returns the parser to its reset state.
    if (end_of_stream_i) begin
      pos_d    = '0;
      recent_d = 24'hffffff;
      chunk_d  = '0;
      search_d = '0;
      group_d  = '0;
      open_d   = 1'b0;
      seen_d   = 1'b0;
      long_d   = 1'b0;
      type_d   = '0;
      known_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      recent_q <= 24'hffffff;
      chunk_q  <= '0;
      search_q <= '0;
      group_q  <= '0;
      open_q   <= 1'b0;
      seen_q   <= 1'b0;
      long_q   <= 1'b0;
      type_q   <= '0;
      known_q  <= 1'b0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      recent_q <= recent_d;
      chunk_q  <= chunk_d;
      search_q <= search_d;
      group_q  <= group_d;
      open_q   <= open_d;
      seen_q   <= seen_d;
      long_q   <= long_d;
      type_q   <= type_d;
      known_q  <= known_d;
    end
  end

endmodule

// File: src/aubs_out_queue.sv
`timescale 1ns / 1ps

module aubs_out_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aubs_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output aubs_pkg::unit_t unit_o
);

  localparam int unsigned PtrW = aubs_pkg::QueuePtrW;
  localparam int unsigned CntW = aubs_pkg::QueueCntW;

  aubs_pkg::unit_t mem_q [aubs_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign unit_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  // Room for the two results one byte can cause.
  assign room_o  = (cnt_q <= CntW'(aubs_pkg::QueueDepth - 2));

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.count);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.unit0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.unit1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/annexb_access_unit_splitter.sv
`timescale 1ns / 1ps

// H.264 Annex B access unit splitter. Bytes of an elementary stream come in
// one per transaction on the slave stream (tlast marks the final byte); the
// block finds 00 00 01 and 00 00 00 01 start codes, reads each NAL's type
// from its header byte, and groups NALs until a slice NAL (type 1 to 5)
// closes the group. Each closed group is sent on the master stream as one
// transaction carrying the access unit's start position and its length in
// bytes, start codes included. A byte causes at most two transactions, and
// tlast is set on the last one a byte causes. Rate: one byte per clock; the
// whole parse for a byte is done combinationally against the state registers,
// and results wait in a four-entry output queue, so the slave side only
// stalls when that queue cannot take two more results (i.e. when the
// consumer falls behind). After the final byte the parser is back in its
// reset state, and the next byte starts a new stream at position 0.
// Positions saturate at their maximum value.

module annexb_access_unit_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_stream
  // Access unit reports
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] unit_start, [63:32] unit_length
  output logic        m_axis_tlast    // last_of_run
);

  logic            accept;
  logic            room;
  aubs_pkg::push_t push;
  aubs_pkg::unit_t head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // Start code search, header decode and grouping
  aubs_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (s_axis_tdata),
    .end_of_stream_i(s_axis_tlast),
    .push_o         (push)
  );

  // Result buffering towards the master side
  aubs_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .unit_o (head)
  );

  assign m_axis_tdata = {head.length, head.start};
  assign m_axis_tlast = head.last;

endmodule
